// ===== design/lkc_pkg.sv =====
`default_nettype none

package lkc_pkg;

    // Number of cells in the recency chain and the width of one key.
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 64;

    // Width of an entry count, which has to hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Width of the size register as it appears on the configuration port.
    localparam int SIZE_W = 5;

    // Operation codes. The code left over behaves like a probe.
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_PROBE  = 2'd2;

    typedef logic [KEY_BITS-1:0] t_key;

    // What one cell is told to do with the item that is accepted this cycle.
    typedef struct packed {
        logic refresh;   // lookup or store: move a hit entry to the front
        logic insert;    // store that missed: every cell shifts by one
        logic in_range;  // cell index is below the configured size
    } t_cell_ctl;

endpackage : lkc_pkg

`default_nettype wire

// ===== design/lkc_cell.sv =====
`default_nettype none

// One position of the recency chain. Position 0 holds the most recent key.
// When told to shift, the cell takes the key and valid bit of its neighbor
// one place nearer the front.
module lkc_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lkc_pkg::t_cell_ctl i_ctl,
    input  wire lkc_pkg::t_key    i_key,
    input  wire lkc_pkg::t_key    i_prev_key,
    input  wire logic             i_prev_valid,
    input  wire logic             i_below,
    output      lkc_pkg::t_key    o_key,
    output      logic             o_valid,
    output      logic             o_below,
    output      lkc_pkg::t_key    o_next_key,
    output      logic             o_next_valid
);
    import lkc_pkg::*;

    t_key r_key;
    logic r_valid;
    t_key n_key;
    logic n_valid;
    logic w_match;
    logic w_shift;

    // The hit chain runs from the back to the front: a cell shifts on a
    // refresh when the hit sits at its own place or further back.
    assign w_match = r_valid && (r_key == i_key);
    assign o_below = w_match || i_below;
    assign w_shift = (i_ctl.refresh && o_below) || i_ctl.insert;

    always_comb begin
        if (w_shift) begin
            n_key   = i_prev_key;
            n_valid = i_prev_valid && i_ctl.in_range;
        end else begin
            n_key   = r_key;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key        = r_key;
    assign o_valid      = r_valid;
    assign o_next_key   = n_key;
    assign o_next_valid = n_valid;

endmodule : lkc_cell

`default_nettype wire

// ===== design/lru_key_cache.sv =====
`default_nettype none

// Fully associative key store with least-recently-used replacement. The keys
// live in a chain of cells ordered by recency: the first cell holds the most
// recent key and the last valid cell holds the eviction candidate, so the
// valid cells always form an unbroken run from the front. Every cell compares
// its key with the request at once; a hit on a lookup or store pulls that key
// to the front while the cells ahead of it move back by one place, and a store
// of a new key moves the whole run back by one and drops the last key when the
// configured size is reached. A probe (and the unused operation code) only
// reports. The block takes one item per cycle while its results are taken:
// the compare, the shift and the result all fit in the cycle that accepts
// the item, and the result is held in an output register so a new item is
// accepted in the same cycle as the previous result is taken. A result is
// valid in the cycle after acceptance. The size register (1 to 16; 0 counts
// as 1, larger as 16) is taken only while the store is empty and resets to 16.
module lru_key_cache (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [lkc_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output      logic                     o_in_ready,
    input  wire logic [1:0]               i_op,
    input  wire logic [63:0]              i_key,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    output      logic                     o_hit,
    output      logic                     o_evicted,
    output      logic [63:0]              o_evicted_key,
    output      logic [4:0]               o_occupancy,
    output      logic                     o_is_full,
    output      logic [63:0]              o_victim_key
);
    import lkc_pkg::*;

    logic [CNT_W-1:0] r_size;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic             r_out_valid;
    logic             r_hit;
    logic             r_evicted;
    t_key             r_evicted_key;
    logic [CNT_W-1:0] r_occupancy;
    logic             r_is_full;
    t_key             r_victim_key;

    logic             w_accept;
    logic             w_hit;
    logic             w_full_now;
    logic             w_insert;
    logic             w_evict;
    t_key             w_in_key;
    logic [CNT_W-1:0] w_cfg_size;
    t_key             w_last_key;
    t_key             w_next_last_key;

    t_cell_ctl        w_ctl      [CAPACITY];
    t_key             w_key      [CAPACITY];
    t_key             w_prev_key [CAPACITY];
    t_key             w_next_key [CAPACITY];
    logic [CAPACITY:0] w_valid;
    logic [CAPACITY-1:0] w_prev_valid;
    logic [CAPACITY:0] w_next_valid;
    logic [CAPACITY:0] w_below;

    // An item may enter whenever the output register is free or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_key   = t_key'(i_key);

    // The hit chain ends behind the last cell; its front end is the hit flag.
    assign w_below[CAPACITY]      = 1'b0;
    assign w_valid[CAPACITY]      = 1'b0;
    assign w_next_valid[CAPACITY] = 1'b0;
    assign w_hit                  = w_below[0];

    assign w_full_now = (r_used == r_size);
    assign w_insert   = w_accept && (i_op == OP_STORE) && !w_hit;
    assign w_evict    = w_insert && w_full_now;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_front
                assign w_prev_key[g]   = w_in_key;
                assign w_prev_valid[g] = 1'b1;
            end else begin : g_rest
                assign w_prev_key[g]   = w_key[g-1];
                assign w_prev_valid[g] = w_valid[g-1];
            end

            assign w_ctl[g].refresh  = w_accept && ((i_op == OP_LOOKUP) || (i_op == OP_STORE));
            assign w_ctl[g].insert   = w_insert;
            assign w_ctl[g].in_range = (CNT_W'(g) < r_size);

            lkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[g]),
                .i_key        (w_in_key),
                .i_prev_key   (w_prev_key[g]),
                .i_prev_valid (w_prev_valid[g]),
                .i_below      (w_below[g+1]),
                .o_key        (w_key[g]),
                .o_valid      (w_valid[g]),
                .o_below      (w_below[g]),
                .o_next_key   (w_next_key[g]),
                .o_next_valid (w_next_valid[g])
            );
        end
    endgenerate

    // The last valid cell is the one whose neighbor behind it is empty. At
    // most one cell qualifies, so the keys are simply OR-ed together.
    always_comb begin
        w_last_key      = '0;
        w_next_last_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_valid[i] && !w_valid[i+1]) begin
                w_last_key = w_last_key | w_key[i];
            end
            if (w_next_valid[i] && !w_next_valid[i+1]) begin
                w_next_last_key = w_next_last_key | w_next_key[i];
            end
        end
    end

    // A store of a new key adds one entry unless it had to evict one first.
    always_comb begin
        n_used = r_used;
        if (w_insert && !w_full_now) begin
            n_used = r_used + CNT_W'(1);
        end
    end

    // Out-of-range sizes are clamped when written.
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            w_cfg_size = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(CAPACITY)) begin
            w_cfg_size = CNT_W'(CAPACITY);
        end else begin
            w_cfg_size = CNT_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CNT_W'(CAPACITY);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (r_used == '0)) begin
                r_size <= w_cfg_size;
            end
            r_used <= n_used;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit         <= w_hit;
            r_evicted     <= w_evict;
            r_evicted_key <= w_evict ? w_last_key : '0;
            r_occupancy   <= n_used;
            r_is_full     <= (n_used == r_size);
            r_victim_key  <= (n_used == r_size) ? w_next_last_key : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = 64'(r_evicted_key);
    assign o_occupancy   = 5'(r_occupancy);
    assign o_is_full     = r_is_full;
    assign o_victim_key  = 64'(r_victim_key);

    // The count of entries never passes the configured size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_size)
        else $error("entry count above configured size");

    // The valid bits and the entry count always agree.
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_used))
        else $error("valid bits disagree with entry count");

    // The valid cells form one unbroken run, with at most one end in the chain.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid[CAPACITY-1:0] & ~w_valid[CAPACITY:1]))
        else $error("more than one end of the valid run");

    // An eviction happens only on a miss and leaves the store full.
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_evicted) |-> (r_is_full && !r_hit))
        else $error("eviction without a full store");

endmodule : lru_key_cache

`default_nettype wire
